/* design/bipl_pkg.sv */
// Package for the button, idle-power and status-LED controller.
// Holds the word types, register map, power-mode codes and fixed widths.
// No dependencies; every other design file imports it.
package bipl_pkg;

  // Field and state widths
  localparam int IDLE_CFG_W = 20;
  localparam int DEB_W      = 10;
  localparam int ACK_W      = 13;
  localparam int PING_W     = 16;
  localparam int AGE_W      = 16;
  localparam int PHASE_W    = 11;
  localparam int LED_W      = 8;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_ADDR_W = 3;

  // Blink pattern edges within the blink period
  localparam int BLINK_ON1_END  = 120;
  localparam int BLINK_OFF1_END = 240;
  localparam int BLINK_ON2_END  = 360;

  // LED full-scale level
  localparam logic [LED_W-1:0] LED_FULL = 8'd255;
  localparam logic [LED_W-1:0] LED_OFF  = 8'd0;

  // Register reset values
  localparam logic [IDLE_CFG_W-1:0] IDLE_LIGHT_RST   = 20'd300000;
  localparam logic [IDLE_CFG_W-1:0] IDLE_DEEP_RST    = 20'd900000;
  localparam logic [DEB_W-1:0]      DEBOUNCE_RST     = 10'd40;
  localparam logic [ACK_W-1:0]      LINK_TIMEOUT_RST = 13'd4000;
  localparam logic [PING_W-1:0]     PING_PERIOD_RST  = 16'd500;
  localparam logic [LED_W-1:0]      BREATH_PEAK_RST  = 8'd51;
  localparam logic [LED_W-1:0]      LINKED_BRIGHT_RST = 8'd64;

  // Register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IDLE_LIGHT    = 3'd0,
    CFG_IDLE_DEEP     = 3'd1,
    CFG_DEBOUNCE      = 3'd2,
    CFG_LINK_TIMEOUT  = 3'd3,
    CFG_PING_PERIOD   = 3'd4,
    CFG_BREATH_PEAK   = 3'd5,
    CFG_LINKED_BRIGHT = 3'd6,
    CFG_LED_INVERT    = 3'd7
  } cfg_idx_t;

  // Power modes
  typedef enum logic [1:0] {
    PM_ACTIVE = 2'd0,
    PM_LIGHT  = 2'd1,
    PM_DEEP   = 2'd2
  } power_mode_t;

  // Configuration register bank
  typedef struct packed {
    logic [IDLE_CFG_W-1:0] light_lim;
    logic [IDLE_CFG_W-1:0] deep_lim;
    logic [DEB_W-1:0]      settle_lim;
    logic [ACK_W-1:0]      link_timeout_ms;
    logic [PING_W-1:0]     ping_period_ms;
    logic [LED_W-1:0]      breath_peak;
    logic [LED_W-1:0]      linked_brightness;
    logic                  led_invert;
  } cfg_t;

  // Input word: one millisecond tick
  typedef struct packed {
    logic button_one_active;
    logic button_two_active;
    logic ack_seen;
    logic radio_accepts;
  } in_t;

  // Result word
  typedef struct packed {
    logic [LED_W-1:0] led_level;
    logic             send_one;
    logic             send_two;
    logic             send_ping;
    logic [1:0]       power_mode;
    logic             link_up;
  } out_t;

endpackage

/* design/bipl_cfg_regs.sv */
// Configuration register bank of the controller.
// Depends on bipl_pkg for the register map and the cfg_t layout.
module bipl_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bipl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bipl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bipl_pkg::cfg_t                  cfg_q,
  output bipl_pkg::cfg_t                  cfg_next
);
  import bipl_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a write into the addressed register, truncated to its width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_IDLE_LIGHT:    cfg_nxt.light_lim         = cfg_wdata[IDLE_CFG_W-1:0];
        CFG_IDLE_DEEP:     cfg_nxt.deep_lim          = cfg_wdata[IDLE_CFG_W-1:0];
        CFG_DEBOUNCE:      cfg_nxt.settle_lim        = cfg_wdata[DEB_W-1:0];
        CFG_LINK_TIMEOUT:  cfg_nxt.link_timeout_ms   = cfg_wdata[ACK_W-1:0];
        CFG_PING_PERIOD:   cfg_nxt.ping_period_ms    = cfg_wdata[PING_W-1:0];
        CFG_BREATH_PEAK:   cfg_nxt.breath_peak       = cfg_wdata[LED_W-1:0];
        CFG_LINKED_BRIGHT: cfg_nxt.linked_brightness = cfg_wdata[LED_W-1:0];
        CFG_LED_INVERT:    cfg_nxt.led_invert        = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register bank with its reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_lim         <= IDLE_LIGHT_RST;
      cfg_r.deep_lim          <= IDLE_DEEP_RST;
      cfg_r.settle_lim        <= DEBOUNCE_RST;
      cfg_r.link_timeout_ms   <= LINK_TIMEOUT_RST;
      cfg_r.ping_period_ms    <= PING_PERIOD_RST;
      cfg_r.breath_peak       <= BREATH_PEAK_RST;
      cfg_r.linked_brightness <= LINKED_BRIGHT_RST;
      cfg_r.led_invert        <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_q    = cfg_r;
  assign cfg_next = cfg_nxt;

endmodule

/* design/bipl_debounce.sv */
// One armed button debouncer: level tracker, stable-time counter and arm flag.
// Depends on bipl_pkg for widths.
module bipl_debounce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       active,
  input  logic                       level,
  input  logic [bipl_pkg::DEB_W-1:0] settle_lim,
  output logic                       fire
);
  import bipl_pkg::*;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  logic             last_r, last_nxt;
  logic             armed_r, armed_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             changed;
  logic [AGE_W-1:0] age_eff;
  logic [AGE_W-1:0] age_base;

  // Press detection; the tracker only follows the level in active mode.
  always_comb begin
    changed  = (level != last_r);
    age_eff  = changed ? '0 : age_r;
    fire     = active && level && armed_r && (age_eff > AGE_W'(settle_lim));
    last_nxt = active ? level : last_r;
    armed_nxt = armed_r;
    if (active) begin
      if (!level) begin
        armed_nxt = 1'b1;
      end else if (fire) begin
        armed_nxt = 1'b0;
      end
    end
    // The stable age advances on every tick and saturates.
    age_base = (active && changed) ? '0 : age_r;
    age_nxt  = (age_base == AGE_MAX) ? age_base : age_base + AGE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= 1'b0;
      armed_r <= 1'b1;
      age_r   <= '0;
    end else if (step) begin
      last_r  <= last_nxt;
      armed_r <= armed_nxt;
      age_r   <= age_nxt;
    end
  end

endmodule

/* design/bipl_breath.sv */
// Breathing triangle generator: registered peak-times-distance product and a
// reciprocal multiply that divides it by half the breath period.
// Depends on bipl_pkg for widths.
module bipl_breath #(
  parameter int BREATH_PERIOD = 2000
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bipl_pkg::PHASE_W-1:0] phase_next,
  input  logic [bipl_pkg::LED_W-1:0]   peak_next,
  output logic [bipl_pkg::LED_W-1:0]   breath_level
);
  import bipl_pkg::*;

  localparam int PROD_W  = LED_W + PHASE_W;
  localparam int HALF    = BREATH_PERIOD / 2;
  localparam int SHIFT   = PROD_W + $clog2(HALF);
  localparam int RECIP_W = PROD_W + 1;
  localparam int SCALE_W = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(HALF) - 64'd1) / 64'(HALF));
  localparam logic [PHASE_W-1:0] HALF_P   = PHASE_W'(HALF);
  localparam logic [PHASE_W-1:0] PERIOD_P = PHASE_W'(BREATH_PERIOD);

  logic [PHASE_W-1:0] dist_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [SCALE_W-1:0] scaled;
  logic [SCALE_W-1:0] quot;

  // Distance from the nearest end of the triangle for the coming phase.
  always_comb begin
    dist_nxt = (phase_next < HALF_P) ? phase_next : PERIOD_P - phase_next;
    prod_nxt = PROD_W'(peak_next) * PROD_W'(dist_nxt);
  end

  // The product tracks the phase and peak registers one for one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
    end else begin
      prod_r <= prod_nxt;
    end
  end

  // Exact floor division by the half period, then saturation.
  always_comb begin
    scaled = SCALE_W'(prod_r) * SCALE_W'(RECIP);
    quot   = scaled >> SHIFT;
    breath_level = (quot > SCALE_W'(LED_FULL)) ? LED_FULL : quot[LED_W-1:0];
  end

endmodule

/* design/button_idle_power_led_controller.sv */
// Button, idle-power and status-LED controller. Each input word is one
// millisecond tick carrying two button levels, an acknowledge flag and a
// radio-accept flag; each word yields exactly one result word with the LED
// duty, the send requests, the power mode and the link state. The block
// takes one word per clock cycle while the result side is not stalled:
// an input register feeds one compute stage that updates all timers and
// debouncers and loads the result register, which presents the result.
// Configuration writes take effect at the next clock edge. Deep mode,
// once entered, holds until reset.
module button_idle_power_led_controller #(
  parameter int BREATH_PERIOD = 2000,
  parameter int BLINK_PERIOD  = 2000,
  parameter int IDLE_BITS     = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bipl_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bipl_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [bipl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bipl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bipl_pkg::*;

  localparam int CMP_W = (IDLE_BITS > IDLE_CFG_W) ? IDLE_BITS : IDLE_CFG_W;
  localparam logic [IDLE_BITS-1:0] IDLE_MAX = '1;
  localparam logic [ACK_W-1:0]     ACK_MAX  = '1;
  localparam logic [PING_W-1:0]    PING_MAX = '1;
  localparam logic [PHASE_W-1:0]   BLINK_LAST  = PHASE_W'(BLINK_PERIOD - 1);
  localparam logic [PHASE_W-1:0]   BREATH_LAST = PHASE_W'(BREATH_PERIOD - 1);

  cfg_t cfg;
  cfg_t cfg_nxt;

  // Pipeline control
  logic in_vld_r;
  in_t  in_data_r;
  logic out_vld_r;
  out_t out_data_r;
  logic step;

  // Timers and LED state
  logic [IDLE_BITS-1:0] idle_r, idle_nxt, idle_eff;
  logic [ACK_W-1:0]     ack_age_r, ack_age_nxt, ack_eff;
  logic [PING_W-1:0]    ping_age_r, ping_age_nxt, ping_eff;
  logic [PHASE_W-1:0]   blink_r, blink_nxt;
  logic [PHASE_W-1:0]   breath_r, breath_nxt, breath_phase_next;
  logic [LED_W-1:0]     held_led_r, held_nxt;
  logic [LED_W-1:0]     blink_lvl;
  logic [LED_W-1:0]     breath_lvl;

  power_mode_t mode;
  logic        link;
  logic        fire_one, fire_two;
  logic        s1, s2, sp;
  logic        idle_clr;
  logic        active_step;
  out_t        result;

  bipl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_q     (cfg),
    .cfg_next  (cfg_nxt)
  );

  // Input register and result register handshakes.
  assign step     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (step) begin
        in_vld_r <= 1'b0;
      end
      if (step) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  // Power mode from the idle timer; a saturated timer always means deep.
  always_comb begin
    if (idle_r == IDLE_MAX) begin
      mode = PM_DEEP;
    end else if (CMP_W'(idle_r) < CMP_W'(cfg.light_lim)) begin
      mode = PM_ACTIVE;
    end else if (CMP_W'(idle_r) < CMP_W'(cfg.deep_lim)) begin
      mode = PM_LIGHT;
    end else begin
      mode = PM_DEEP;
    end
  end

  assign active_step = step && (mode == PM_ACTIVE);

  bipl_debounce u_deb_one (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .active     (active_step),
    .level      (in_data_r.button_one_active),
    .settle_lim (cfg.settle_lim),
    .fire       (fire_one)
  );

  bipl_debounce u_deb_two (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .active     (active_step),
    .level      (in_data_r.button_two_active),
    .settle_lim (cfg.settle_lim),
    .fire       (fire_two)
  );

  // Double blink pattern over the blink period.
  always_comb begin
    if (blink_r < PHASE_W'(BLINK_ON1_END)) begin
      blink_lvl = LED_FULL;
    end else if (blink_r < PHASE_W'(BLINK_OFF1_END)) begin
      blink_lvl = LED_OFF;
    end else if (blink_r < PHASE_W'(BLINK_ON2_END)) begin
      blink_lvl = LED_FULL;
    end else begin
      blink_lvl = LED_OFF;
    end
  end

  // Per-tick work: sends, ping, LED level and timer updates.
  always_comb begin
    ack_eff  = in_data_r.ack_seen ? '0 : ack_age_r;
    link     = (ack_eff < cfg.link_timeout_ms);
    s1       = 1'b0;
    s2       = 1'b0;
    sp       = 1'b0;
    ping_eff = ping_age_r;
    held_nxt = held_led_r;
    case (mode)
      PM_ACTIVE: begin
        s1 = fire_one;
        s2 = fire_two;
        if (ping_age_r >= cfg.ping_period_ms) begin
          sp       = 1'b1;
          ping_eff = '0;
        end
        if (in_data_r.button_one_active || in_data_r.button_two_active) begin
          held_nxt = LED_FULL;
        end else if (link) begin
          held_nxt = cfg.linked_brightness;
        end else begin
          held_nxt = blink_lvl;
        end
      end
      PM_LIGHT: begin
        if (in_data_r.button_one_active) begin
          s1 = 1'b1;
        end else if (in_data_r.button_two_active) begin
          s2 = 1'b1;
        end else begin
          held_nxt = breath_lvl;
        end
      end
      default: begin
        held_nxt = LED_OFF;
      end
    endcase

    // An accepted button send restarts the idle timer and the breath phase.
    idle_clr = (s1 || s2) && in_data_r.radio_accepts;
    idle_eff = idle_clr ? '0 : idle_r;
    if (mode == PM_DEEP) begin
      idle_nxt = IDLE_MAX;
    end else if (idle_eff != IDLE_MAX) begin
      idle_nxt = idle_eff + IDLE_BITS'(1);
    end else begin
      idle_nxt = idle_eff;
    end
    if (idle_clr) begin
      breath_nxt = PHASE_W'(1);
    end else begin
      breath_nxt = (breath_r == BREATH_LAST) ? '0 : breath_r + PHASE_W'(1);
    end
    blink_nxt    = (blink_r == BLINK_LAST) ? '0 : blink_r + PHASE_W'(1);
    ack_age_nxt  = (ack_eff == ACK_MAX) ? ack_eff : ack_eff + ACK_W'(1);
    ping_age_nxt = (ping_eff == PING_MAX) ? ping_eff : ping_eff + PING_W'(1);

    result.led_level  = cfg.led_invert ? ~held_nxt : held_nxt;
    result.send_one   = s1;
    result.send_two   = s2;
    result.send_ping  = sp;
    result.power_mode = mode;
    result.link_up    = link;
  end

  assign breath_phase_next = step ? breath_nxt : breath_r;

  bipl_breath #(
    .BREATH_PERIOD (BREATH_PERIOD)
  ) u_breath (
    .clk          (clk),
    .rst_n        (rst_n),
    .phase_next   (breath_phase_next),
    .peak_next    (cfg_nxt.breath_peak),
    .breath_level (breath_lvl)
  );

  // Controller state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r     <= '0;
      ack_age_r  <= '0;
      ping_age_r <= '0;
      blink_r    <= '0;
      breath_r   <= '0;
      held_led_r <= '0;
    end else if (step) begin
      idle_r     <= idle_nxt;
      ack_age_r  <= ack_age_nxt;
      ping_age_r <= ping_age_nxt;
      blink_r    <= blink_nxt;
      breath_r   <= breath_nxt;
      held_led_r <= held_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Deep mode is latched: a saturated idle timer never leaves saturation.
  a_deep_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (idle_r == IDLE_MAX) |=> (idle_r == IDLE_MAX))
    else $error("idle timer left deep-mode saturation");

  // A deep-mode result carries no send requests.
  a_deep_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_data_r.power_mode == PM_DEEP)) |->
      (!out_data_r.send_one && !out_data_r.send_two && !out_data_r.send_ping))
    else $error("send request in deep mode");

  // Pings are only requested in active mode, and light idle sends one button.
  a_light_sends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_data_r.power_mode == PM_LIGHT)) |->
      (!out_data_r.send_ping && !(out_data_r.send_one && out_data_r.send_two)))
    else $error("bad send pattern in light idle");

  // The input side stalls only behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a blocked result");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the button, idle-power and status-LED controller.
// Predicts every status word from the tick words it sends; uses bipl_pkg only.
// Covers active, light-idle and deep modes under random stalls on both sides.
`timescale 1ns / 100ps

module tb_top;
  import bipl_pkg::*;

  localparam int BREATH_PERIOD = 2000;
  localparam int BLINK_PERIOD  = 2000;
  localparam int IDLE_BITS     = 20;
  localparam int TAIL_CYCLES   = 20;
  localparam int IDLE_TOP      = 1048575;

  localparam logic [IDLE_BITS-1:0] IDLE_MAX = '1;
  localparam logic [ACK_W-1:0]     ACK_MAX  = '1;
  localparam logic [AGE_W-1:0]     AGE_MAX  = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  button_idle_power_led_controller #(
    .BREATH_PERIOD(BREATH_PERIOD),
    .BLINK_PERIOD (BLINK_PERIOD),
    .IDLE_BITS    (IDLE_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Register copy and timer state of the predictor.
  cfg_t                 shadow;
  logic [IDLE_BITS-1:0] idle_age;
  logic [ACK_W-1:0]     ack_age;
  logic [PING_W-1:0]    ping_age;
  logic [PHASE_W-1:0]   blink_phase;
  logic [PHASE_W-1:0]   breath_phase;
  logic [1:0]           last_level;
  logic [AGE_W-1:0]     stable_age [2];
  logic [1:0]           armed;
  logic [LED_W-1:0]     held_led;

  out_t expected_status [$];
  int   ticks_sent;
  int   status_checked;
  int   mismatches;
  int   mode_ticks [3];

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Debounce one button; returns 1 in the tick a press fires.
  function automatic logic debounce_press(int k, logic level);
    if (level != last_level[k]) begin
      last_level[k] = level;
      stable_age[k] = '0;
    end
    if (!level) begin
      armed[k] = 1'b1;
      return 1'b0;
    end
    if (armed[k] && stable_age[k] > shadow.settle_lim) begin
      armed[k] = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Double blink: on, off, on, then dark for the rest of the period.
  function automatic logic [LED_W-1:0] blink_value();
    if (blink_phase < BLINK_ON1_END) return LED_FULL;
    if (blink_phase < BLINK_OFF1_END) return LED_OFF;
    if (blink_phase < BLINK_ON2_END) return LED_FULL;
    return LED_OFF;
  endfunction

  // Triangle ramp over the breathing period, saturating at full scale.
  function automatic logic [LED_W-1:0] breath_value();
    int half;
    int t;
    int peak;
    int v;
    half = BREATH_PERIOD / 2;
    t = int'(breath_phase);
    peak = int'(shadow.breath_peak);
    if (half == 0) return LED_OFF;
    if (t < half) v = (peak * t) / half;
    else v = (peak * (BREATH_PERIOD - t)) / half;
    return (v > 255) ? LED_FULL : v[LED_W-1:0];
  endfunction

  // Advance the predictor by one millisecond tick and return its status word.
  function automatic out_t predict_status(in_t w);
    out_t        r;
    power_mode_t mode;
    logic        s1;
    logic        s2;
    logic        sp;
    logic        link;
    s1 = 1'b0;
    s2 = 1'b0;
    sp = 1'b0;
    if (w.ack_seen) ack_age = '0;
    link = (ack_age < shadow.link_timeout_ms);

    if (idle_age == IDLE_MAX) mode = PM_DEEP;
    else if (idle_age < shadow.light_lim) mode = PM_ACTIVE;
    else if (idle_age < shadow.deep_lim) mode = PM_LIGHT;
    else mode = PM_DEEP;

    case (mode)
      PM_ACTIVE: begin
        s1 = debounce_press(0, w.button_one_active);
        s2 = debounce_press(1, w.button_two_active);
        if (ping_age >= shadow.ping_period_ms) begin
          ping_age = '0;
          sp = 1'b1;
        end
        if (w.button_one_active || w.button_two_active) held_led = LED_FULL;
        else if (link) held_led = shadow.linked_brightness;
        else held_led = blink_value();
      end
      PM_LIGHT: begin
        // Button one wins when both are held; the LED holds its level.
        if (w.button_one_active) s1 = 1'b1;
        else if (w.button_two_active) s2 = 1'b1;
        else held_led = breath_value();
      end
      default: held_led = LED_OFF;
    endcase

    if ((s1 || s2) && w.radio_accepts) begin
      idle_age = '0;
      breath_phase = '0;
    end
    if (mode == PM_DEEP) idle_age = IDLE_MAX;
    else if (idle_age != IDLE_MAX) idle_age = idle_age + 1'b1;
    breath_phase = PHASE_W'((breath_phase + 1) % BREATH_PERIOD);

    if (ack_age != ACK_MAX) ack_age = ack_age + 1'b1;
    if (ping_age != AGE_MAX) ping_age = ping_age + 1'b1;
    for (int k = 0; k < 2; k++)
      if (stable_age[k] != AGE_MAX) stable_age[k] = stable_age[k] + 1'b1;
    blink_phase = PHASE_W'((blink_phase + 1) % BLINK_PERIOD);

    mode_ticks[mode]++;
    r.led_level  = shadow.led_invert ? (LED_FULL - held_led) : held_led;
    r.send_one   = s1;
    r.send_two   = s2;
    r.send_ping  = sp;
    r.power_mode = mode;
    r.link_up    = link;
    return r;
  endfunction

  function automatic void reset_model();
    shadow.light_lim         = IDLE_LIGHT_RST;
    shadow.deep_lim          = IDLE_DEEP_RST;
    shadow.settle_lim        = DEBOUNCE_RST;
    shadow.link_timeout_ms   = LINK_TIMEOUT_RST;
    shadow.ping_period_ms    = PING_PERIOD_RST;
    shadow.breath_peak       = BREATH_PEAK_RST;
    shadow.linked_brightness = LINKED_BRIGHT_RST;
    shadow.led_invert        = 1'b0;
    idle_age      = '0;
    ack_age       = '0;
    ping_age      = '0;
    blink_phase   = '0;
    breath_phase  = '0;
    last_level    = '0;
    stable_age[0] = '0;
    stable_age[1] = '0;
    armed         = 2'b11;
    held_led      = LED_OFF;
  endfunction

  function automatic in_t tick_word(logic b1, logic b2, logic ack, logic acc);
    in_t w;
    w.button_one_active = b1;
    w.button_two_active = b2;
    w.ack_seen          = ack;
    w.radio_accepts     = acc;
    return w;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted status word with the oldest prediction.
  always @(posedge clk) begin : check_status
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $display("%0t: status word %h arrived with nothing expected", $time, out_data);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        status_checked++;
        compare_field("led_level", want.led_level, out_data.led_level);
        compare_field("send_one", 8'(want.send_one), 8'(out_data.send_one));
        compare_field("send_two", 8'(want.send_two), 8'(out_data.send_two));
        compare_field("send_ping", 8'(want.send_ping), 8'(out_data.send_ping));
        compare_field("power_mode", 8'(want.power_mode), 8'(out_data.power_mode));
        compare_field("link_up", 8'(want.link_up), 8'(out_data.link_up));
      end
    end
  end

  // Receiver back-pressure: a new stall style after each run of random length.
  initial begin : rx_stall_pattern
    int          style;
    logic [15:0] pat;
    out_ready = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      pat = 16'($urandom) | 16'h0001;
      repeat ($urandom_range(50, 250)) begin
        @(negedge clk);
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 2) != 0);
          2: begin
            out_ready <= pat[0];
            pat = {pat[0], pat[15:1]};
          end
          default: if ($urandom_range(0, 7) == 0) out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // Send one tick word; called and returns at a falling edge with valid still high.
  task automatic send_tick(in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    expected_status.push_back(predict_status(w));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
  endtask

  // Register write; the block is drained first so no word sees a half-applied setting.
  task automatic write_reg(cfg_idx_t idx, int unsigned v);
    wait_all_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v[CFG_DATA_W-1:0];
    case (idx)
      CFG_IDLE_LIGHT:    shadow.light_lim = v[IDLE_CFG_W-1:0];
      CFG_IDLE_DEEP:     shadow.deep_lim = v[IDLE_CFG_W-1:0];
      CFG_DEBOUNCE:      shadow.settle_lim = v[DEB_W-1:0];
      CFG_LINK_TIMEOUT:  shadow.link_timeout_ms = v[ACK_W-1:0];
      CFG_PING_PERIOD:   shadow.ping_period_ms = v[PING_W-1:0];
      CFG_BREATH_PEAK:   shadow.breath_peak = v[LED_W-1:0];
      CFG_LINKED_BRIGHT: shadow.linked_brightness = v[LED_W-1:0];
      CFG_LED_INVERT:    shadow.led_invert = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(int unsigned light, int unsigned deep, int unsigned deb,
                                int unsigned link, int unsigned ping, int unsigned peak,
                                int unsigned bright, int unsigned inv);
    write_reg(CFG_IDLE_LIGHT, light);
    write_reg(CFG_IDLE_DEEP, deep);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LINK_TIMEOUT, link);
    write_reg(CFG_PING_PERIOD, ping);
    write_reg(CFG_BREATH_PEAK, peak);
    write_reg(CFG_LINKED_BRIGHT, bright);
    write_reg(CFG_LED_INVERT, inv);
  endtask

  // Random button traffic: held and released runs with short contact bounce,
  // sent in bursts with random gaps.
  task automatic random_ticks(int n, int hold_max, int rest_max, int ack_pct, int acc_pct);
    int         left [2];
    logic [1:0] lvl;
    int         burst;
    logic       ack;
    logic       acc;
    lvl = '0;
    left[0] = 0;
    left[1] = 0;
    burst = $urandom_range(1, 60);
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 2; k++) begin
        if (left[k] == 0) begin
          lvl[k] = ~lvl[k];
          if ($urandom_range(0, 99) < 15) left[k] = $urandom_range(1, 2);
          else if (lvl[k]) left[k] = $urandom_range(1, hold_max);
          else left[k] = $urandom_range(1, rest_max);
        end
        left[k]--;
      end
      ack = ($urandom_range(0, 99) < ack_pct);
      acc = ($urandom_range(0, 99) < acc_pct);
      send_tick(tick_word(lvl[0], lvl[1], ack, acc));
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 60);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 7));
      end
    end
  endtask

  // Reset values: linked at start, then every input bit high at once.
  task automatic test_power_on_defaults();
    send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(tick_word(1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(tick_word(1'b0, 1'b0, 1'b1, 1'b0));
  endtask

  // Zero debounce and a zero ping period; both buttons fire together on one accept.
  task automatic test_debounce_and_ping();
    apply_settings(IDLE_TOP, IDLE_TOP, 0, 4000, 0, 51, 64, 0);
    send_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1));
    send_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1));
    send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(tick_word(1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(tick_word(1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(tick_word(1'b0, 1'b1, 1'b0, 1'b1));
    send_tick(tick_word(1'b0, 1'b1, 1'b0, 1'b1));
  endtask

  // A zero link timeout never links; with a timeout of one only the ack tick links.
  task automatic test_link_timeout();
    write_reg(CFG_LINK_TIMEOUT, 0);
    send_tick(tick_word(1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0));
    write_reg(CFG_LINK_TIMEOUT, 1);
    send_tick(tick_word(1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  // Light idle: immediate sends with button one first, LED held during a send.
  task automatic test_light_idle_sends();
    write_reg(CFG_IDLE_LIGHT, 2);
    send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1));
    send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(tick_word(1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_led_invert();
    write_reg(CFG_LED_INVERT, 1);
    write_reg(CFG_BREATH_PEAK, 255);
    send_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(tick_word(1'b1, 1'b0, 1'b0, 1'b0));
    write_reg(CFG_LED_INVERT, 0);
  endtask

  // Random phases, each under its own register setting.
  task automatic test_random_traffic();
    // Active only, fast debounce, ping every tick, dark linked level, inverted.
    apply_settings(IDLE_TOP, IDLE_TOP, $urandom_range(0, 6), $urandom_range(1, 60), 1,
                   255, 0, 1);
    random_ticks(300, 20, 30, 5, 75);
    // Frequent hand-over between active and light idle.
    apply_settings($urandom_range(10, 60), IDLE_TOP, $urandom_range(0, 8), 8191, 65535,
                   $urandom_range(0, 255), 255, 0);
    random_ticks(350, 15, 150, 10, 75);
    // Light idle almost always; long quiet runs walk the breathing ramp.
    apply_settings(1, IDLE_TOP, 1000, $urandom_range(1, 8191), $urandom_range(1, 65535),
                   255, $urandom_range(0, 255), 1);
    random_ticks(400, 5, 800, 3, 30);
    // Everything random.
    apply_settings($urandom_range(1, 40), IDLE_TOP, $urandom_range(0, 30),
                   $urandom_range(1, 200), $urandom_range(1, 100), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 1));
    random_ticks(300, 60, 40, 8, 75);
  endtask

  // Deep mode last, since only reset leaves it: reach it, then show that
  // neither buttons nor register changes bring the block back.
  task automatic test_deep_latch();
    apply_settings(6, 12, 0, 100, 5, 51, 64, 0);
    random_ticks(24, 4, 4, 20, 0);
    apply_settings(1, 1, 0, 100, 5, 51, 64, 0);
    random_ticks(8, 3, 3, 50, 100);
    apply_settings(IDLE_TOP, IDLE_TOP, 0, 8191, 1, 255, 255, 1);
    random_ticks(8, 3, 3, 50, 100);
  endtask

  // Test sequence.
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    ticks_sent = 0;
    status_checked = 0;
    mismatches = 0;
    for (int m = 0; m < 3; m++) mode_ticks[m] = 0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_power_on_defaults();
    test_debounce_and_ping();
    test_link_timeout();
    test_light_idle_sends();
    test_led_invert();
    test_random_traffic();
    test_deep_latch();

    wait_all_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d ticks, checked %0d status words, %0d mismatches.",
             ticks_sent, status_checked, mismatches);
    $display("Ticks per mode: active %0d, light idle %0d, deep %0d.",
             mode_ticks[PM_ACTIVE], mode_ticks[PM_LIGHT], mode_ticks[PM_DEEP]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/bipl_pkg.sv
design/bipl_cfg_regs.sv
design/bipl_debounce.sv
design/bipl_breath.sv
design/button_idle_power_led_controller.sv
dv/tb_top.sv
